[sv/oint_pkg.sv]
// Shared types and constants for the online IoU suppression table.
package oint_pkg;

    localparam int CLASS_W  = 8;
    localparam int CONF_W   = 14;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int THR_W    = 8;
    localparam int TAG_W    = 6;
    localparam logic [THR_W-1:0] THR_RESET = 8'd128;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPEND   = 3'd0,
        ST_REPLACE  = 3'd1,
        ST_SUPPRESS = 3'd2,
        ST_DROP     = 3'd3,
        ST_DRAIN    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_AREA,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_REPORT,
        S_DRAIN_RD,
        S_DRAIN_EMIT
    } seq_state_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic             conf_gt;
        logic [TAG_W-1:0] tag;
    } iou_res_t;

endpackage

[sv/oint_in_if.sv]
// Input channel: offered box or drain command.
interface oint_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [7:0]                   class_id;
    logic [13:0]                  confidence;
    logic signed [COORD_BITS-1:0] left_edge;
    logic signed [COORD_BITS-1:0] top_edge;
    logic signed [COORD_BITS-1:0] right_edge;
    logic signed [COORD_BITS-1:0] bottom_edge;

    modport source (
        output valid, operation, class_id, confidence,
        output left_edge, top_edge, right_edge, bottom_edge,
        input  ready
    );
    modport sink (
        input  valid, operation, class_id, confidence,
        input  left_edge, top_edge, right_edge, bottom_edge,
        output ready
    );
endinterface

[sv/oint_out_if.sv]
// Output channel: offer outcome or drained table entry.
interface oint_out_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [5:0]                   entry_index;
    logic [7:0]                   out_class;
    logic [13:0]                  out_confidence;
    logic signed [COORD_BITS-1:0] out_left;
    logic signed [COORD_BITS-1:0] out_top;
    logic signed [COORD_BITS-1:0] out_right;
    logic signed [COORD_BITS-1:0] out_bottom;
    logic                         last;

    modport source (
        output valid, status, entry_index, out_class, out_confidence,
        output out_left, out_top, out_right, out_bottom, last,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, out_class, out_confidence,
        input  out_left, out_top, out_right, out_bottom, last,
        output ready
    );
endinterface

[sv/oint_table_mem.sv]
// Box table storage: one write port, one registered read port.
module oint_table_mem #(
    parameter int WIDTH = 86,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[sv/oint_iou_unit.sv]
// Pipelined class and IoU threshold test of one stored box per cycle.
module oint_iou_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             kill,
    input  logic                             issue_valid,
    input  logic [oint_pkg::TAG_W-1:0]       issue_tag,
    input  logic [4*COORD_BITS+21:0]         entry,
    input  logic [oint_pkg::CLASS_W-1:0]     new_class,
    input  logic [oint_pkg::CONF_W-1:0]      new_conf,
    input  logic signed [COORD_BITS-1:0]     new_left,
    input  logic signed [COORD_BITS-1:0]     new_top,
    input  logic signed [COORD_BITS-1:0]     new_right,
    input  logic signed [COORD_BITS-1:0]     new_bottom,
    input  logic signed [2*COORD_BITS+1:0]   new_area,
    input  logic [oint_pkg::THR_W-1:0]       thr,
    output oint_pkg::iou_res_t               res
);
    import oint_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int D_W = CB + 1;
    localparam int P_W = 2 * CB + 2;
    localparam int U_W = 2 * CB + 4;
    localparam int C_W = 2 * CB + 12;

    logic signed [CB-1:0]    e_left, e_top, e_right, e_bottom;
    logic [CLASS_W-1:0]      e_class;
    logic [CONF_W-1:0]       e_conf;
    logic signed [CB-1:0]    min_r, max_l, min_b, max_t;
    logic signed [D_W-1:0]   w_comb, h_comb;

    logic [4:0]              v_reg;
    logic [TAG_W-1:0]        tag0_reg, tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic                    cand1_reg, cand2_reg, cand3_reg, cand4_reg;
    logic                    gt1_reg, gt2_reg, gt3_reg, gt4_reg;
    logic signed [D_W-1:0]   w_reg, h_reg, dw_reg, dh_reg;
    logic signed [P_W-1:0]   inter2_reg, ub_reg;
    logic signed [U_W-1:0]   uni_reg;
    logic [P_W-2:0]          inter3_reg, inter4_reg;
    logic                    uni_pos_reg, uni_zero_reg;
    logic [C_W-1:0]          prod_reg;
    logic [P_W+6:0]          inter_sh;
    iou_res_t                res_reg;

    assign e_bottom = entry[CB-1:0];
    assign e_right  = entry[2*CB-1:CB];
    assign e_top    = entry[3*CB-1:2*CB];
    assign e_left   = entry[4*CB-1:3*CB];
    assign e_conf   = entry[4*CB+CONF_W-1:4*CB];
    assign e_class  = entry[4*CB+CONF_W+CLASS_W-1:4*CB+CONF_W];

    assign min_r  = (new_right < e_right) ? new_right : e_right;
    assign max_l  = (new_left > e_left) ? new_left : e_left;
    assign min_b  = (new_bottom < e_bottom) ? new_bottom : e_bottom;
    assign max_t  = (new_top > e_top) ? new_top : e_top;
    assign w_comb = {min_r[CB-1], min_r} - {max_l[CB-1], max_l};
    assign h_comb = {min_b[CB-1], min_b} - {max_t[CB-1], max_t};

    assign inter_sh = {inter4_reg, 8'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            res_reg <= '0;
        end
        else if (kill)
        begin
            v_reg   <= '0;
            res_reg <= '0;
        end
        else
        begin
            v_reg         <= {v_reg[3:0], issue_valid};
            res_reg.valid <= v_reg[4];
            res_reg.hit   <= cand4_reg & (uni_zero_reg |
                             (uni_pos_reg & (C_W'(inter_sh) > prod_reg)));
            res_reg.conf_gt <= gt4_reg;
            res_reg.tag     <= tag4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag0_reg <= issue_tag;

        w_reg     <= w_comb;
        h_reg     <= h_comb;
        dw_reg    <= {e_right[CB-1], e_right} - {e_left[CB-1], e_left};
        dh_reg    <= {e_bottom[CB-1], e_bottom} - {e_top[CB-1], e_top};
        cand1_reg <= (e_class == new_class) && (w_comb > 0) && (h_comb > 0);
        gt1_reg   <= new_conf > e_conf;
        tag1_reg  <= tag0_reg;

        inter2_reg <= w_reg * h_reg;
        ub_reg     <= dw_reg * dh_reg;
        cand2_reg  <= cand1_reg;
        gt2_reg    <= gt1_reg;
        tag2_reg   <= tag1_reg;

        uni_reg    <= U_W'(new_area) + U_W'(ub_reg) - U_W'(inter2_reg);
        inter3_reg <= inter2_reg[P_W-2:0];
        cand3_reg  <= cand2_reg;
        gt3_reg    <= gt2_reg;
        tag3_reg   <= tag2_reg;

        prod_reg     <= C_W'(thr) * C_W'(uni_reg[U_W-2:0]);
        uni_pos_reg  <= (uni_reg > 0);
        uni_zero_reg <= (uni_reg == '0);
        inter4_reg   <= inter3_reg;
        cand4_reg    <= cand3_reg;
        gt4_reg      <= gt3_reg;
        tag4_reg     <= tag3_reg;
    end

    assign res = res_reg;
endmodule

[sv/online_iou_nms_table.sv]
// Top level of the online IoU suppression table with its sequencer.
// An offered box walks the table from entry 0 through one pipelined IoU unit, one
// entry issued per cycle; the scan ends early on a hit, and a replace closes the gap
// by moving each later entry down one slot before the new box is written at the end.
// A drain reads the entries out in order, gated by the output ready.
// Results wait in an output register, so the next item is taken while one is pending.
// The IoU threshold is written through cfg_wr_en and cfg_wr_data; the user must do so
// only while the block is idle, as the block itself does not enforce this.
module online_iou_nms_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int COORD_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [oint_pkg::THR_W-1:0] cfg_wr_data,
    oint_in_if.sink                in_ch,
    oint_out_if.source             out_ch
);
    import oint_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int D_W     = CB + 1;
    localparam int P_W     = 2 * CB + 2;
    localparam int ENTRY_W = 4 * CB + CONF_W + CLASS_W;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [INDEX_W-1:0] DROP_IDX = INDEX_W'(TABLE_DEPTH);

    seq_state_t state_reg, state_next;

    logic [THR_W-1:0]      thr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      issue_idx_reg;
    logic [IDX_W-1:0]      shift_j_reg, wr_pos_reg, drain_idx_reg;
    logic                  incr_reg;
    status_t               status_reg;
    logic [INDEX_W-1:0]    index_reg;

    logic [CLASS_W-1:0]    n_class_reg;
    logic [CONF_W-1:0]     n_conf_reg;
    logic signed [CB-1:0]  n_left_reg, n_top_reg, n_right_reg, n_bottom_reg;
    logic signed [D_W-1:0] n_dw_reg, n_dh_reg;
    logic signed [P_W-1:0] n_area_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   o_status_reg;
    logic [INDEX_W-1:0]    o_index_reg;
    logic [CLASS_W-1:0]    o_class_reg;
    logic [CONF_W-1:0]     o_conf_reg;
    logic signed [CB-1:0]  o_left_reg, o_top_reg, o_right_reg, o_bottom_reg;
    logic                  o_last_reg;

    logic                  in_accept, slot_free, full, drain_last;
    logic                  res_done, shift_needed;
    logic                  rd_en, wr_en, issue, kill, load_out;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    logic [ENTRY_W-1:0]    rd_data, wr_data, new_entry;
    iou_res_t              res;

    assign in_accept  = in_ch.valid && in_ch.ready;
    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign full       = (count_reg == FULL_CNT);
    assign drain_last = (CNT_W'(drain_idx_reg) + CNT_W'(1) == count_reg);
    assign res_done   = res.valid &&
                        (res.hit || (CNT_W'(res.tag) == count_reg - CNT_W'(1)));
    assign shift_needed = (CNT_W'(res.tag) + CNT_W'(1) < count_reg);
    assign new_entry  = {n_class_reg, n_conf_reg, n_left_reg, n_top_reg,
                         n_right_reg, n_bottom_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_ch.operation == OP_DRAIN)
                    begin
                        state_next = (count_reg != '0) ? S_DRAIN_RD : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                state_next = S_AREA;
            end
            S_AREA:
            begin
                state_next = (count_reg == '0) ? S_WRITE : S_SCAN;
            end
            S_SCAN:
            begin
                if (res_done)
                begin
                    if (res.hit && res.conf_gt)
                    begin
                        state_next = shift_needed ? S_SHIFT_RD : S_WRITE;
                    end
                    else if (res.hit || full)
                    begin
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = (CNT_W'(shift_j_reg) + CNT_W'(2) < count_reg) ?
                             S_SHIFT_RD : S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN_RD:
            begin
                state_next = S_DRAIN_EMIT;
            end
            S_DRAIN_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = drain_last ? S_IDLE : S_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = wr_pos_reg;
        wr_data  = new_entry;
        issue    = 1'b0;
        kill     = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_SCAN:
            begin
                issue   = (issue_idx_reg < count_reg) && !res_done;
                rd_en   = issue;
                rd_addr = issue_idx_reg[IDX_W-1:0];
                kill    = res_done;
            end
            S_SHIFT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = shift_j_reg + IDX_W'(1);
            end
            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = shift_j_reg;
                wr_data = rd_data;
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
            end
            S_REPORT:
            begin
                load_out = slot_free;
            end
            S_DRAIN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = drain_idx_reg;
            end
            S_DRAIN_EMIT:
            begin
                load_out = slot_free;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= THR_RESET;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (state_reg == S_WRITE && incr_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (state_reg == S_DRAIN_EMIT && slot_free && drain_last)
            begin
                count_reg <= '0;
            end
            if (state_reg == S_AREA)
            begin
                issue_idx_reg <= '0;
            end
            else if (issue)
            begin
                issue_idx_reg <= issue_idx_reg + CNT_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            n_class_reg   <= in_ch.class_id;
            n_conf_reg    <= in_ch.confidence;
            n_left_reg    <= in_ch.left_edge;
            n_top_reg     <= in_ch.top_edge;
            n_right_reg   <= in_ch.right_edge;
            n_bottom_reg  <= in_ch.bottom_edge;
            drain_idx_reg <= '0;
        end
        if (state_reg == S_PREP)
        begin
            n_dw_reg <= {n_right_reg[CB-1], n_right_reg} - {n_left_reg[CB-1], n_left_reg};
            n_dh_reg <= {n_bottom_reg[CB-1], n_bottom_reg} - {n_top_reg[CB-1], n_top_reg};
        end
        if (state_reg == S_AREA)
        begin
            n_area_reg <= n_dw_reg * n_dh_reg;
            status_reg <= ST_APPEND;
            index_reg  <= '0;
            wr_pos_reg <= '0;
            incr_reg   <= 1'b1;
        end
        if (state_reg == S_SCAN && res_done)
        begin
            if (res.hit && res.conf_gt)
            begin
                status_reg  <= ST_REPLACE;
                index_reg   <= INDEX_W'(res.tag);
                incr_reg    <= 1'b0;
                shift_j_reg <= res.tag[IDX_W-1:0];
                wr_pos_reg  <= IDX_W'(count_reg - CNT_W'(1));
            end
            else if (res.hit)
            begin
                status_reg <= ST_SUPPRESS;
                index_reg  <= INDEX_W'(res.tag);
                incr_reg   <= 1'b0;
            end
            else if (full)
            begin
                status_reg <= ST_DROP;
                index_reg  <= DROP_IDX;
                incr_reg   <= 1'b0;
            end
            else
            begin
                status_reg <= ST_APPEND;
                index_reg  <= INDEX_W'(count_reg);
                wr_pos_reg <= count_reg[IDX_W-1:0];
                incr_reg   <= 1'b1;
            end
        end
        if (state_reg == S_SHIFT_WR)
        begin
            shift_j_reg <= shift_j_reg + IDX_W'(1);
        end
        if (state_reg == S_REPORT && load_out)
        begin
            o_status_reg <= status_reg;
            o_index_reg  <= index_reg;
            o_class_reg  <= '0;
            o_conf_reg   <= '0;
            o_left_reg   <= '0;
            o_top_reg    <= '0;
            o_right_reg  <= '0;
            o_bottom_reg <= '0;
            o_last_reg   <= 1'b1;
        end
        if (state_reg == S_DRAIN_EMIT && load_out)
        begin
            o_status_reg  <= ST_DRAIN;
            o_index_reg   <= INDEX_W'(drain_idx_reg);
            o_class_reg   <= rd_data[ENTRY_W-1:4*CB+CONF_W];
            o_conf_reg    <= rd_data[4*CB+CONF_W-1:4*CB];
            o_left_reg    <= rd_data[4*CB-1:3*CB];
            o_top_reg     <= rd_data[3*CB-1:2*CB];
            o_right_reg   <= rd_data[2*CB-1:CB];
            o_bottom_reg  <= rd_data[CB-1:0];
            o_last_reg    <= drain_last;
            drain_idx_reg <= drain_idx_reg + IDX_W'(1);
        end
    end

    oint_table_mem #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    oint_iou_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .clk         (clk),
        .rst_n       (rst_n),
        .kill        (kill),
        .issue_valid (issue),
        .issue_tag   (TAG_W'(issue_idx_reg)),
        .entry       (rd_data),
        .new_class   (n_class_reg),
        .new_conf    (n_conf_reg),
        .new_left    (n_left_reg),
        .new_top     (n_top_reg),
        .new_right   (n_right_reg),
        .new_bottom  (n_bottom_reg),
        .new_area    (n_area_reg),
        .thr         (thr_reg),
        .res         (res)
    );

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = o_status_reg;
    assign out_ch.entry_index    = o_index_reg;
    assign out_ch.out_class      = o_class_reg;
    assign out_ch.out_confidence = o_conf_reg;
    assign out_ch.out_left       = o_left_reg;
    assign out_ch.out_top        = o_top_reg;
    assign out_ch.out_right      = o_right_reg;
    assign out_ch.out_bottom     = o_bottom_reg;
    assign out_ch.last           = o_last_reg;

    // hold: compare results only ever arrive during a scan
    a_res_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> state_reg == S_SCAN)
        else $error("compare result outside scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond table depth");

    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_ch.operation == OP_DRAIN && count_reg != '0)
        |=> state_reg == S_DRAIN_RD)
        else $error("drain did not start");

    a_drain_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN_EMIT && slot_free && drain_last)
        |=> (count_reg == '0 && out_valid_reg && o_last_reg))
        else $error("table not cleared after last drained item");
endmodule
